// ===== hw/rtl/fsqrt_pkg.sv =====
// Package: shared types and constants for the single-precision square root
package fsqrt_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned RootBits  = 25;  // 24 mantissa bits plus round bit
  localparam int unsigned RemWidth  = 27;
  localparam logic [31:0] QnanDefault = 32'h7FC0_0000;
  localparam logic [31:0] QuietBit    = 32'h0040_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_ROOT,
    ST_ROUND,
    ST_OUT
  } state_t;

  // control from sequencer to the recurrence unit
  typedef struct packed {
    logic load;
    logic step;
  } rec_ctrl_t;

endpackage

// ===== hw/rtl/fsqrt_rec.sv =====
// Restoring digit-recurrence square root: one root bit per step
module fsqrt_rec (
  input  logic                              clk,
  input  fsqrt_pkg::rec_ctrl_t              ctrl,
  input  logic [24:0]                       mant,   // radicand mantissa, < 2^25
  output logic [fsqrt_pkg::RootBits-1:0]    root,
  output logic                              sticky
);

  // partial remainder, remaining radicand bits (two per step), root so far
  logic [fsqrt_pkg::RemWidth-1:0] rem;
  logic [49:0]                    rad;
  logic [fsqrt_pkg::RootBits-1:0] q;
  logic [fsqrt_pkg::RemWidth-1:0] trial;
  logic [fsqrt_pkg::RemWidth-1:0] shifted;

  always_comb begin
    shifted = {rem[fsqrt_pkg::RemWidth-3:0], rad[49:48]};
    trial   = shifted - {q, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= '0;
      rad <= {mant, 25'd0};
      q   <= '0;
    end else if (ctrl.step) begin
      rad <= {rad[47:0], 2'b00};
      if (shifted >= {q, 2'b01}) begin
        rem <= trial;
        q   <= {q[fsqrt_pkg::RootBits-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[fsqrt_pkg::RootBits-2:0], 1'b0};
      end
    end
  end

  assign root   = q;
  assign sticky = (rem != '0);

endmodule

// ===== hw/rtl/float_square_root.sv =====
// Top level: sequencer, unpacking, rounding and packing of the square root
// Square root of one binary32 value, round to nearest even. A transaction
// is accepted, then normalised: no shift for a normal input with even
// exponent, one shift with odd exponent; subnormals shift until the leading
// bit is set, plus one if the exponent is then odd (one shift a cycle).
// Then come the one-bit-a-step recurrence for all 25 root bits, a rounding
// state and an output state that presents the result. Specials (NaN, zeros,
// infinity, negatives) go from normalisation straight to the output state.
// The block takes one transaction at a time; the result is held until taken.
module float_square_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] radicand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] root_bits,
  output logic        invalid_flag
);

  fsqrt_pkg::state_t    state, state_next;
  fsqrt_pkg::rec_ctrl_t rctl;

  logic [24:0] m;
  logic [9:0]  e;        // signed unbiased exponent
  logic [4:0]  cnt;
  logic [31:0] res;
  logic        inv;
  logic        special;
  logic [fsqrt_pkg::RootBits-1:0] q;
  logic        sticky;
  logic [9:0]  e_half;
  logic [31:0] packed_r;

  fsqrt_rec u_rec (.clk(clk), .ctrl(rctl), .mant(m), .root(q), .sticky(sticky));

  assign in_stall     = (state != fsqrt_pkg::ST_IDLE);
  assign out_valid    = (state == fsqrt_pkg::ST_OUT);
  assign root_bits    = res;
  assign invalid_flag = inv;

  always_ff @(posedge clk) begin
    if (rst) state <= fsqrt_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    rctl       = '0;
    case (state)
      fsqrt_pkg::ST_IDLE: if (in_valid) state_next = fsqrt_pkg::ST_NORM;
      fsqrt_pkg::ST_NORM: begin
        if (special) state_next = fsqrt_pkg::ST_OUT;
        else if ((m[24] || m[23]) && !e[0]) begin
          rctl.load  = 1'b1;
          state_next = fsqrt_pkg::ST_ROOT;
        end
      end
      fsqrt_pkg::ST_ROOT: begin
        rctl.step = 1'b1;
        if (cnt == 5'd24) state_next = fsqrt_pkg::ST_ROUND;
      end
      fsqrt_pkg::ST_ROUND: state_next = fsqrt_pkg::ST_OUT;
      fsqrt_pkg::ST_OUT:   if (!out_stall) state_next = fsqrt_pkg::ST_IDLE;
      default:             state_next = fsqrt_pkg::ST_IDLE;
    endcase
  end

  // odd exponent: double the mantissa; result exponent is floor(e/2)
  always_comb begin
    e_half   = {e[9], e[9:1]} + 10'd127;
    packed_r = {1'b0, e_half[7:0], q[23:1]};
    if (q[0] && (sticky || q[1])) packed_r = packed_r + 32'd1;
  end

  always_ff @(posedge clk) begin
    case (state)
      fsqrt_pkg::ST_IDLE: if (in_valid) begin
        inv     <= 1'b0;
        special <= 1'b1;
        res     <= radicand_bits;
        m       <= {1'b0, (radicand_bits[30:23] != 8'd0), radicand_bits[22:0]};
        e       <= (radicand_bits[30:23] == 8'd0) ? -10'sd126
                   : {2'b00, radicand_bits[30:23]} - 10'd127;
        if (radicand_bits[30:23] == 8'hFF && radicand_bits[22:0] != '0)
          res <= radicand_bits | fsqrt_pkg::QuietBit;
        else if (radicand_bits[30:0] == '0) res <= radicand_bits;
        else if (radicand_bits[31]) begin
          res <= fsqrt_pkg::QnanDefault;
          inv <= 1'b1;
        end else if (radicand_bits[30:23] == 8'hFF) res <= radicand_bits;
        else special <= 1'b0;
      end
      fsqrt_pkg::ST_NORM: begin
        cnt <= '0;
        if (!special) begin
          if (!(m[24] || m[23])) begin
            m <= {m[23:0], 1'b0};
            e <= e - 10'd1;
          end else if (e[0]) begin
            m <= {m[23:0], 1'b0};
            e <= e - 10'd1;
          end
        end
      end
      fsqrt_pkg::ST_ROOT:  cnt <= cnt + 5'd1;
      fsqrt_pkg::ST_ROUND: res <= packed_r;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_inv_nan: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid_flag |-> root_bits == fsqrt_pkg::QnanDefault)
    else $error("invalid without default NaN");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == fsqrt_pkg::ST_ROOT |-> in_stall && !out_valid)
    else $error("busy overlap");
  a_root_len: assert property (@(posedge clk) disable iff (rst)
    $rose(state == fsqrt_pkg::ST_ROUND) |-> $past(cnt) == 5'd24)
    else $error("recurrence length");
`endif

endmodule

// ===== test/float_square_root_test.sv =====
// Testbench for the single-precision square root: directed and random operands, self-checking
`timescale 1ns / 1ps

module float_square_root_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] radicand_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] root_bits;
  logic        invalid_flag;

  typedef struct packed {
    logic [31:0] root;
    logic        invalid;
  } root_result_t;

  root_result_t pending_roots[$];
  int unsigned  sent_count = 0;
  int unsigned  taken_count = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  special_count = 0;
  int unsigned  subnormal_count = 0;
  bit           hold_receiver = 1'b0;
  bit           no_gaps = 1'b0;

  float_square_root u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .radicand_bits (radicand_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .root_bits     (root_bits),
    .invalid_flag  (invalid_flag)
  );

  always #6 clk = ~clk;

  initial begin
    #50_000_000;
    $display("float_square_root regression: fail");
    $finish;
  end

  // exactly rounded binary32 square root, digit by digit
  function automatic root_result_t predict_root(logic [31:0] x);
    root_result_t r;
    logic [7:0]   expf;
    logic [22:0]  frac;
    logic [49:0]  op;
    logic [49:0]  acc;
    logic [49:0]  bitv;
    logic [24:0]  m;
    logic [23:0]  mant;
    int           e;
    expf = x[30:23];
    frac = x[22:0];
    r.invalid = 1'b0;
    if (expf == 8'hFF && frac != 0) begin
      r.root = x | fsqrt_pkg::QuietBit;
    end else if (x[30:0] == 0) begin
      r.root = x;
    end else if (x[31]) begin
      r.root = fsqrt_pkg::QnanDefault;
      r.invalid = 1'b1;
    end else if (expf == 8'hFF) begin
      r.root = x;
    end else begin
      if (expf == 0) begin
        m = {2'b0, frac};
        e = -126;
        while (!m[23]) begin
          m = m << 1;
          e--;
        end
      end else begin
        m = {2'b01, frac};
        e = int'(expf) - 127;
      end
      if (e % 2 != 0) begin
        m = m << 1;
        e--;
      end
      op = {m, 25'b0};
      acc = '0;
      bitv = 50'd1 << 48;
      while (bitv != 0) begin
        if (op >= acc + bitv) begin
          op = op - (acc + bitv);
          acc = (acc >> 1) + bitv;
        end else begin
          acc = acc >> 1;
        end
        bitv = bitv >> 2;
      end
      mant = acc[24:1];
      r.root = ({24'b0, 8'(e / 2 + 127)} << 23) + {9'b0, mant[22:0]};
      if (acc[0] && (op != 0 || mant[0])) r.root = r.root + 1;
    end
    return r;
  endfunction

  task automatic idle_cycles(int unsigned n);
    repeat (n) @(posedge clk);
  endtask

  // valid stays high after a transaction unless a gap follows
  task automatic send_radicand(logic [31:0] x);
    root_result_t r;
    int unsigned  gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      idle_cycles(gap);
    end
    in_valid <= 1'b1;
    radicand_bits <= x;
    do @(posedge clk); while (in_stall);
    r = predict_root(x);
    pending_roots.push_back(r);
    sent_count++;
    if (x[30:23] == 8'hFF || x[31] || x[30:0] == 0) special_count++;
    else if (x[30:23] == 0) subnormal_count++;
  endtask

  // receiver: random stall per transaction, long hold when requested
  initial begin
    int unsigned waits;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_stall <= 1'b1;
      end else if (waits > 0) begin
        out_stall <= 1'b1;
        waits--;
      end else begin
        out_stall <= 1'b0;
      end
      if (out_valid && !out_stall) waits = no_gaps ? 0 : $urandom_range(0, 4);
    end
  end

  // result check
  always @(posedge clk) begin
    root_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      taken_count++;
      if (pending_roots.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result root=%h invalid=%b", root_bits, invalid_flag);
      end else begin
        exp_r = pending_roots.pop_front();
        if (root_bits !== exp_r.root || invalid_flag !== exp_r.invalid) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected root=%h invalid=%b, got root=%h invalid=%b",
                     exp_r.root, exp_r.invalid, root_bits, invalid_flag);
        end
      end
    end
  end

  function automatic logic [31:0] random_operand();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(0, 9))
      0:       x[30:23] = 8'h00;
      1:       x[30:23] = 8'hFF;
      2:       x[31] = 1'b1;
      default: x[31] = 1'b0;
    endcase
    return x;
  endfunction

  task automatic test_specials();
    send_radicand(32'h0000_0000);
    send_radicand(32'h8000_0000);
    send_radicand(32'h7F80_0000);
    send_radicand(32'hFF80_0000);
    send_radicand(32'h7F80_0001);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'h7FC0_0000);
    send_radicand(32'hFFA5_5555);
    send_radicand(32'hBF80_0000);
    send_radicand(32'h8000_0001);
  endtask

  task automatic test_extremes();
    send_radicand(32'h0000_0001);
    send_radicand(32'h007F_FFFF);
    send_radicand(32'h0040_0000);
    send_radicand(32'h0080_0000);
    send_radicand(32'h7F7F_FFFF);
    send_radicand(32'h3F80_0000);
    send_radicand(32'h4000_0000);
    send_radicand(32'h4080_0000);
    send_radicand(32'h3F7F_FFFF);
    send_radicand(32'h4040_0000);
    send_radicand(32'h5555_AAAA);
  endtask

  task automatic test_random(int unsigned n);
    repeat (n) send_radicand(random_operand());
  endtask

  // receiver holds off while the sender keeps offering, so input backs up
  task automatic test_backpressure();
    fork
      begin
        hold_receiver = 1'b1;
        idle_cycles(300);
        hold_receiver = 1'b0;
      end
      test_random(20);
    join
  endtask

  task automatic test_back_to_back(int unsigned n);
    no_gaps = 1'b1;
    test_random(n);
    no_gaps = 1'b0;
  endtask

  initial begin
    int unsigned guard;
    idle_cycles(5);
    rst <= 1'b0;
    test_specials();
    test_extremes();
    test_backpressure();
    test_back_to_back(200);
    test_random(1700);
    in_valid <= 1'b0;
    guard = 0;
    while (pending_roots.size() != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    idle_cycles(40);
    $display("covered %0d operands (%0d special, %0d subnormal), %0d results checked",
             sent_count, special_count, subnormal_count, taken_count);
    if (mismatch_count == 0 && pending_roots.size() == 0) begin
      $display("float_square_root regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pending_roots.size());
      $display("float_square_root regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fsqrt_pkg.sv
hw/rtl/fsqrt_rec.sv
hw/rtl/float_square_root.sv
test/float_square_root_test.sv
